>>> hw/rtl/truck_drone_route_evaluator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the route evaluator RTL
// Implication and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TRUCK_DRONE_ROUTE_EVALUATOR_TOP_DEFINES_SVH
`define TRUCK_DRONE_ROUTE_EVALUATOR_TOP_DEFINES_SVH

// Same-cycle implication
`define TDRE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TDRE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tdre_pkg.sv
// ----------------------------------------------------------------------------
// Route evaluator package
// Shared constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package tdre_pkg;

    // Parameter defaults
    localparam int COORD_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    // Fixed field widths
    localparam int CUST_W   = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int POW_W      = 33;
    localparam int ELIM_W     = 40;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPOT   = 3'd0,
        REG_TRUCK_T = 3'd1,
        REG_DRONE_T = 3'd2,
        REG_VERT_T  = 3'd3,
        REG_PPW     = 3'd4,
        REG_BASE_P  = 3'd5,
        REG_CAP     = 3'd6,
        REG_BATT    = 3'd7
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_TMUL,
        S_SQX,
        S_SQY,
        S_ROOT_GO,
        S_ROOT,
        S_CRUISE,
        S_SEG,
        S_ACC,
        S_SVC,
        S_POWER,
        S_PADD,
        S_ECHK,
        S_EMUL,
        S_DONE
    } state_t;

endpackage

>>> hw/rtl/tdre_isqrt.sv
// ----------------------------------------------------------------------------
// Digit-serial integer square root
// Produces floor(sqrt(radicand)), one root bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module tdre_isqrt #(
    parameter int SQ_W = 2 * tdre_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [SQ_W-1:0]         radicand,
    output logic                    done,
    output logic [(SQ_W+1)/2-1:0]   root
);
    import tdre_pkg::*;

    localparam int RN = (SQ_W + 1) / 2;
    localparam int N2 = 2 * RN;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [N2-1:0] v_reg, v_next;
    logic [N2-1:0] r_reg, r_next;
    logic [N2-1:0] b_reg, b_next;
    logic [N2-1:0] rb;

    // One restoring step per cycle
    always_comb
    begin
        run_next  = run_reg;
        done_next = done_reg;
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        rb        = r_reg + b_reg;
        if (start)
        begin
            run_next  = 1'b1;
            done_next = 1'b0;
            v_next    = N2'(radicand);
            r_next    = '0;
            b_next    = N2'(1) << (N2 - 2);
        end
        else if (run_reg)
        begin
            if (v_reg >= rb)
            begin
                v_next = v_reg - rb;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            if (b_reg[0])
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign root = r_reg[RN-1:0];

endmodule

>>> hw/rtl/truck_drone_route_evaluator_top.sv
// ----------------------------------------------------------------------------
// Truck / drone route evaluator
// Usage: customers of one route enter on the s_ stream, one transaction each,
// in visiting order; s_tlast marks the final customer and s_tuser the route
// kind (taken from the first customer). The route starts and ends at the
// depot in the configuration registers, written on the cfg_ channel; the user
// must write them only while no route is in progress, which the block does
// not enforce. One result leaves on the m_ stream after the last customer:
// time, energy, feasibility and a saturation flag. Steps: a truck leg runs
// difference, product, clamp, accumulate; a drone leg runs difference, both
// squares, square root, product, clamp, accumulate. The digit-serial square
// root takes one root bit per cycle, and CE is the coordinate width (min of
// COORD_WIDTH and 16). Each customer adds accept and service steps; the next
// is taken only after them. The closing drone leg adds the bit-serial energy
// product and the result load. A stalled receiver holds the result in the
// output register; the block keeps taking customers and only waits at the end
// of the next route. Reset clears route state and loads register defaults.
// ----------------------------------------------------------------------------
`include "truck_drone_route_evaluator_top_defines.svh"

module truck_drone_route_evaluator_top #(
    parameter int COORD_WIDTH = tdre_pkg::COORD_WIDTH_DEF,
    parameter int TIME_WIDTH  = tdre_pkg::TIME_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // customer stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] cust_x, [31:16] cust_y, [47:32] demand, [63:48] svc_time,
    // [64] droneable, [71:65] zero
    input  logic [tdre_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] cmd
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] route_time, [63:32] route_energy, [64] feasible,
    // [65] saturated, [71:66] zero
    output logic [tdre_pkg::OUT_DATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tdre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                         cfg_data
);
    import tdre_pkg::*;

    localparam int CE   = (COORD_WIDTH < CUST_W) ? COORD_WIDTH : CUST_W;
    localparam int SQ_W = 2 * CE + 1;
    localparam int RN   = CE + 1;
    localparam int LB0  = (CE + 21 > 32) ? CE + 21 : 32;
    localparam int LW   = ((TIME_WIDTH > LB0) ? TIME_WIDTH : LB0) + 1;
    localparam int SW   = (TIME_WIDTH > ELIM_W) ? TIME_WIDTH : ELIM_W;
    localparam int RXW  = (TIME_WIDTH > 33) ? TIME_WIDTH : 33;
    localparam logic [LW-1:0] TMAX_L = (LW'(1) << TIME_WIDTH) - LW'(1);
    localparam logic [ELIM_W+1:0] ELIM = (42'(1) << ELIM_W) - 42'(1);

    // Configuration registers
    logic [31:0] depot_reg;
    logic [15:0] ttpu_reg, dtpu_reg, ppw_reg, bp_reg;
    logic [31:0] vt_reg, batt_reg;
    logic [23:0] cap_reg;

    // Route state
    state_t                state_reg, state_next;
    logic                  started_reg, started_next;
    logic                  kind_reg, kind_next;
    logic                  ret_reg, ret_next;
    logic [TIME_WIDTH-1:0] time_sum_reg, time_sum_next;
    logic [TIME_WIDTH-1:0] seg_sum_reg, seg_sum_next;
    logic [23:0]           weight_reg, weight_next;
    logic                  all_dr_reg, all_dr_next;
    logic                  ovf_reg, ovf_next;
    logic                  wover_reg, wover_next;
    logic                  sover_reg, sover_next;
    logic [CE-1:0]         prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;

    // Item and leg payload
    logic                  last_reg, last_next, dr_reg, dr_next;
    logic [15:0]           demand_reg, demand_next, svc_reg, svc_next;
    logic [CE-1:0]         fx_reg, fx_next, fy_reg, fy_next;
    logic [CE-1:0]         tx_reg, tx_next, ty_reg, ty_next;
    logic [CE-1:0]         dx_reg, dx_next, dy_reg, dy_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [LW-1:0]         leg_reg, leg_next;
    logic                  legov_reg, legov_next;

    // Energy
    logic [ELIM_W-1:0]     wprod_reg, wprod_next;
    logic [POW_W-1:0]      pow_reg, pow_next;
    logic [ELIM_W-1:0]     acc_reg, acc_next;
    logic                  eover_reg, eover_next;
    logic [5:0]            cnt_reg, cnt_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Control from the sequencer and the square root unit
    logic          root_start, load_out;
    logic          root_done;
    logic [RN-1:0] root;

    // Combinational helpers
    logic [CE-1:0]      depot_x, depot_y;
    logic [CE:0]        tsum;
    logic [CE+16:0]     tprod;
    logic [RN+15:0]     cprod;
    logic [2*CE-1:0]    sqm;
    logic [LW-1:0]      cl, segv, tsx, ssx, svx;
    logic               tov, sov, tov2, sov2;
    logic [24:0]        wx;
    logic [SW-1:0]      seg_ext;
    logic               seg_hi;
    logic [ELIM_W+1:0]  nacc;
    logic [RXW-1:0]     rtx;
    logic               rclamp, feas, sat;
    logic [31:0]        rt, energy;

    assign depot_x = depot_reg[CE-1:0];
    assign depot_y = depot_reg[16+CE-1:16];

    // Square root unit
    tdre_isqrt #(
        .SQ_W (SQ_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sq_reg),
        .done     (root_done),
        .root     (root)
    );

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depot_reg <= '0;
            ttpu_reg  <= 16'd256;
            dtpu_reg  <= 16'd256;
            vt_reg    <= '0;
            ppw_reg   <= '0;
            bp_reg    <= '0;
            cap_reg   <= 24'hFFFFFF;
            batt_reg  <= 32'hFFFFFFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEPOT:   depot_reg <= cfg_data;
                REG_TRUCK_T: ttpu_reg  <= cfg_data[15:0];
                REG_DRONE_T: dtpu_reg  <= cfg_data[15:0];
                REG_VERT_T:  vt_reg    <= cfg_data;
                REG_PPW:     ppw_reg   <= cfg_data[15:0];
                REG_BASE_P:  bp_reg    <= cfg_data[15:0];
                REG_CAP:     cap_reg   <= cfg_data[23:0];
                REG_BATT:    batt_reg  <= cfg_data;
                default:     depot_reg <= depot_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_DIFF;
            S_DIFF:    state_next = kind_reg ? S_SQX : S_TMUL;
            S_TMUL:    state_next = S_SEG;
            S_SQX:     state_next = S_SQY;
            S_SQY:     state_next = S_ROOT_GO;
            S_ROOT_GO: state_next = S_ROOT;
            S_ROOT:    if (root_done) state_next = S_CRUISE;
            S_CRUISE:  state_next = S_SEG;
            S_SEG:     state_next = S_ACC;
            S_ACC:
            begin
                if (!ret_reg)
                    state_next = S_SVC;
                else
                    state_next = kind_reg ? S_POWER : S_DONE;
            end
            S_SVC:     state_next = last_reg ? S_DIFF : S_IDLE;
            S_POWER:   state_next = S_PADD;
            S_PADD:    state_next = S_ECHK;
            S_ECHK:
            begin
                if (pow_reg == '0 || sover_reg || seg_hi)
                    state_next = S_DONE;
                else
                    state_next = S_EMUL;
            end
            S_EMUL:    if (nacc > ELIM || cnt_reg == '0) state_next = S_DONE;
            S_DONE:    if (!out_valid_reg || m_tready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready   = 1'b0;
        root_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:    s_tready   = 1'b1;
            S_ROOT_GO: root_start = 1'b1;
            S_DONE:    load_out   = !out_valid_reg || m_tready;
            default:   s_tready   = 1'b0;
        endcase
    end

    // Arithmetic of the current step
    always_comb
    begin
        tsum    = {1'b0, dx_reg} + {1'b0, dy_reg};
        tprod   = (CE+17)'(tsum) * (CE+17)'(ttpu_reg);
        cprod   = (RN+16)'(root) * (RN+16)'(dtpu_reg);
        sqm     = (state_reg == S_SQX) ? (2*CE)'(dx_reg) * (2*CE)'(dx_reg)
                                       : (2*CE)'(dy_reg) * (2*CE)'(dy_reg);
        tov     = leg_reg > TMAX_L;
        cl      = tov ? TMAX_L : leg_reg;
        segv    = cl + LW'(vt_reg);
        sov     = segv > TMAX_L;
        tsx     = LW'(time_sum_reg) + leg_reg;
        tov2    = tsx > TMAX_L;
        ssx     = LW'(seg_sum_reg) + leg_reg;
        sov2    = ssx > TMAX_L;
        svx     = LW'(time_sum_reg) + LW'({svc_reg, 8'b0});
        wx      = {1'b0, weight_reg} + 25'(demand_reg);
        seg_ext = SW'(seg_sum_reg);
        seg_hi  = seg_ext > SW'(ELIM);
        nacc    = {1'b0, acc_reg, 1'b0}
                  + (pow_reg[cnt_reg] ? (ELIM_W+2)'(seg_ext[ELIM_W-1:0]) : '0);
        rtx     = RXW'(time_sum_reg);
        rclamp  = rtx > RXW'(32'hFFFFFFFF);
        rt      = rclamp ? 32'hFFFFFFFF : rtx[31:0];
        if (!kind_reg)
            energy = '0;
        else if (eover_reg)
            energy = 32'hFFFFFFFF;
        else
            energy = acc_reg[ELIM_W-1:8];
        feas = !kind_reg || (all_dr_reg && !wover_reg && weight_reg <= cap_reg &&
                             !eover_reg && energy <= batt_reg);
        sat  = ovf_reg || sover_reg || rclamp || (kind_reg && eover_reg);
    end

    // Datapath next values
    always_comb
    begin
        started_next   = started_reg;
        kind_next      = kind_reg;
        ret_next       = ret_reg;
        time_sum_next  = time_sum_reg;
        seg_sum_next   = seg_sum_reg;
        weight_next    = weight_reg;
        all_dr_next    = all_dr_reg;
        ovf_next       = ovf_reg;
        wover_next     = wover_reg;
        sover_next     = sover_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        last_next      = last_reg;
        dr_next        = dr_reg;
        demand_next    = demand_reg;
        svc_next       = svc_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sq_next        = sq_reg;
        leg_next       = leg_reg;
        legov_next     = legov_reg;
        wprod_next     = wprod_reg;
        pow_next       = pow_reg;
        acc_next       = acc_reg;
        eover_next     = eover_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // release a taken result
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            // latch the customer and pick the leg start
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    tx_next     = s_tdata[CE-1:0];
                    ty_next     = s_tdata[16+CE-1:16];
                    demand_next = s_tdata[47:32];
                    svc_next    = s_tdata[63:48];
                    dr_next     = s_tdata[64];
                    last_next   = s_tlast;
                    ret_next    = 1'b0;
                    if (started_reg)
                    begin
                        fx_next = prev_x_reg;
                        fy_next = prev_y_reg;
                    end
                    else
                    begin
                        fx_next      = depot_x;
                        fy_next      = depot_y;
                        kind_next    = s_tuser;
                        started_next = 1'b1;
                    end
                end
            end
            S_DIFF:
            begin
                dx_next = (fx_reg > tx_reg) ? fx_reg - tx_reg : tx_reg - fx_reg;
                dy_next = (fy_reg > ty_reg) ? fy_reg - ty_reg : ty_reg - fy_reg;
            end
            S_TMUL:   leg_next = LW'({tprod, 4'b0});
            S_SQX:    sq_next  = SQ_W'(sqm);
            S_SQY:    sq_next  = sq_reg + SQ_W'(sqm);
            S_CRUISE: leg_next = LW'({cprod, 4'b0});
            // clamp the travel time and, for a drone leg, add the vertical time
            S_SEG:
            begin
                if (kind_reg)
                begin
                    leg_next   = sov ? TMAX_L : segv;
                    legov_next = tov || sov;
                end
                else
                begin
                    leg_next   = cl;
                    legov_next = tov;
                end
            end
            // accumulate the leg
            S_ACC:
            begin
                time_sum_next = tov2 ? TIME_WIDTH'(TMAX_L) : tsx[TIME_WIDTH-1:0];
                if (kind_reg)
                begin
                    seg_sum_next = sov2 ? TIME_WIDTH'(TMAX_L) : ssx[TIME_WIDTH-1:0];
                    sover_next   = sover_reg || legov_reg || sov2;
                    ovf_next     = ovf_reg || legov_reg || sov2 || tov2;
                end
                else
                begin
                    ovf_next = ovf_reg || legov_reg || tov2;
                end
            end
            // add service and demand; on the last customer, set up the return leg
            S_SVC:
            begin
                if (svx > TMAX_L)
                begin
                    time_sum_next = TIME_WIDTH'(TMAX_L);
                    ovf_next      = 1'b1;
                end
                else
                begin
                    time_sum_next = svx[TIME_WIDTH-1:0];
                end
                if (wx[24])
                begin
                    weight_next = 24'hFFFFFF;
                    wover_next  = 1'b1;
                    ovf_next    = 1'b1;
                end
                else
                begin
                    weight_next = wx[23:0];
                end
                all_dr_next = all_dr_reg && dr_reg;
                prev_x_next = tx_reg;
                prev_y_next = ty_reg;
                if (last_reg)
                begin
                    fx_next  = tx_reg;
                    fy_next  = ty_reg;
                    tx_next  = depot_x;
                    ty_next  = depot_y;
                    ret_next = 1'b1;
                end
            end
            S_POWER:  wprod_next = ELIM_W'(ppw_reg) * ELIM_W'(weight_reg);
            S_PADD:
            begin
                pow_next   = POW_W'(wprod_reg[ELIM_W-1:8]) + POW_W'(bp_reg);
                acc_next   = '0;
                eover_next = 1'b0;
                cnt_next   = 6'(POW_W - 1);
            end
            S_ECHK:
            begin
                if (pow_reg != '0 && (sover_reg || seg_hi))
                    eover_next = 1'b1;
            end
            // one power bit per cycle, most significant first
            S_EMUL:
            begin
                if (nacc > ELIM)
                    eover_next = 1'b1;
                else
                    acc_next = nacc[ELIM_W-1:0];
                cnt_next = cnt_reg - 6'd1;
            end
            // emit the result and clear the route
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'b0, sat, feas, energy, rt};
                    started_next   = 1'b0;
                    kind_next      = 1'b0;
                    ret_next       = 1'b0;
                    time_sum_next  = '0;
                    seg_sum_next   = '0;
                    weight_next    = '0;
                    all_dr_next    = 1'b1;
                    ovf_next       = 1'b0;
                    wover_next     = 1'b0;
                    sover_next     = 1'b0;
                    prev_x_next    = depot_x;
                    prev_y_next    = depot_y;
                end
            end
            default:  cnt_next = cnt_reg;
        endcase
    end

    // Control and route state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            kind_reg      <= 1'b0;
            ret_reg       <= 1'b0;
            time_sum_reg  <= '0;
            seg_sum_reg   <= '0;
            weight_reg    <= '0;
            all_dr_reg    <= 1'b1;
            ovf_reg       <= 1'b0;
            wover_reg     <= 1'b0;
            sover_reg     <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            kind_reg      <= kind_next;
            ret_reg       <= ret_next;
            time_sum_reg  <= time_sum_next;
            seg_sum_reg   <= seg_sum_next;
            weight_reg    <= weight_next;
            all_dr_reg    <= all_dr_next;
            ovf_reg       <= ovf_next;
            wover_reg     <= wover_next;
            sover_reg     <= sover_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        dr_reg       <= dr_next;
        demand_reg   <= demand_next;
        svc_reg      <= svc_next;
        fx_reg       <= fx_next;
        fy_reg       <= fy_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sq_reg       <= sq_next;
        leg_reg      <= leg_next;
        legov_reg    <= legov_next;
        wprod_reg    <= wprod_next;
        pow_reg      <= pow_next;
        acc_reg      <= acc_next;
        eover_reg    <= eover_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `TDRE_ASSERT_NXT(a_accept_busy, clk, rst_n, s_tvalid && s_tready,
        state_reg != S_IDLE, "accepted customer left sequencer idle")
    `TDRE_ASSERT_NXT(a_done_loads, clk, rst_n, state_reg == S_DONE && !out_valid_reg,
        out_valid_reg, "result not loaded at route end")
    `TDRE_ASSERT_IMP(a_clear_idle, clk, rst_n, !started_reg,
        time_sum_reg == '0 && weight_reg == '0, "route sums not cleared")
    `TDRE_ASSERT_IMP(a_emul_power, clk, rst_n, state_reg == S_EMUL,
        pow_reg != '0 && kind_reg, "energy product without drone power")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route evaluator testbench
// Streams truck and drone routes into the evaluator under several register
// settings and idle patterns. A cycle-free predictor computes each route's
// time, energy and flags on every accepted customer, and the monitor checks
// every result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import tdre_pkg::*;

    localparam logic [63:0] T_MAX   = 64'hFFFF_FFFF;
    localparam logic [63:0] W_MAX   = 64'hFF_FFFF;
    localparam logic [63:0] E_LIM   = (64'h1 << 40) - 1;
    localparam int          SETTLE  = 200;

    typedef struct {
        bit        cmd;
        bit [15:0] x;
        bit [15:0] y;
        bit [15:0] dem;
        bit [15:0] svc;
        bit        dr;
        bit        last;
    } cust_t;

    typedef struct {
        bit [31:0] rt;
        bit [31:0] en;
        bit        feas;
        bit        sat;
    } route_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    cust_t      cust_q[$];
    route_res_t route_q[$];
    cust_t      cur_cust;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         errs = 0;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;
    int         hold_left = 0;

    // shadow registers
    bit [63:0] sh_depot, sh_ttpu, sh_dtpu, sh_vert, sh_ppw, sh_base, sh_cap, sh_batt;
    // shadow route state
    bit [63:0] px, py, t_sum, seg_sum, w_sum;
    bit        started, all_dr, ovf, is_drone, w_over, s_over;

    truck_drone_route_evaluator_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit [63:0] dep_x();
        return sh_depot[15:0];
    endfunction

    function automatic bit [63:0] dep_y();
        return sh_depot[31:16];
    endfunction

    // saturating time add
    function automatic bit [63:0] tadd(input bit [63:0] a, input bit [63:0] b, inout bit ov);
        bit [63:0] s;
        s = a + b;
        if (s > T_MAX)
        begin
            ov = 1'b1;
            s = T_MAX;
        end
        return s;
    endfunction

    function automatic bit [63:0] root64(input bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit [63:0] adiff(input bit [63:0] a, input bit [63:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // add one leg's travel time to the route sums
    task automatic add_leg(input bit [63:0] fx, fy, tx, ty);
        bit [63:0] dx, dy, t, cruise, seg, dummy;
        bit        lo;
        dx = adiff(fx, tx);
        dy = adiff(fy, ty);
        if (!is_drone)
        begin
            t = ((dx + dy) * sh_ttpu) << 4;
            dummy = tadd(0, t, ovf);
            t_sum = tadd(t_sum, (t > T_MAX) ? T_MAX : t, ovf);
        end
        else
        begin
            lo = 1'b0;
            cruise = (root64(dx * dx + dy * dy) * sh_dtpu) << 4;
            seg = tadd((cruise > T_MAX) ? T_MAX : cruise, sh_vert, lo);
            if (cruise > T_MAX)
                lo = 1'b1;
            seg_sum = tadd(seg_sum, seg, lo);
            if (lo)
                s_over = 1'b1;
            t_sum = tadd(t_sum, seg, lo);
            if (lo)
                ovf = 1'b1;
        end
    endtask

    task automatic clear_route();
        px = dep_x();
        py = dep_y();
        started = 1'b0;
        t_sum = 0;
        seg_sum = 0;
        w_sum = 0;
        all_dr = 1'b1;
        ovf = 1'b0;
        is_drone = 1'b0;
        w_over = 1'b0;
        s_over = 1'b0;
    endtask

    // advance the route by one customer; queue the result on the last one
    task automatic eval_customer(input cust_t c);
        bit [63:0]  fx, fy, p, energy;
        bit         sat, e_over;
        route_res_t r;
        fx = px;
        fy = py;
        if (!started)
        begin
            fx = dep_x();
            fy = dep_y();
            is_drone = c.cmd;
            started = 1'b1;
        end
        add_leg(fx, fy, c.x, c.y);
        t_sum = tadd(t_sum, {48'd0, c.svc} << 8, ovf);
        w_sum += c.dem;
        if (w_sum > W_MAX)
        begin
            w_sum = W_MAX;
            w_over = 1'b1;
            ovf = 1'b1;
        end
        if (!c.dr)
            all_dr = 1'b0;
        px = c.x;
        py = c.y;
        if (!c.last)
            return;
        add_leg(c.x, c.y, dep_x(), dep_y());
        sat = ovf || s_over;
        energy = 0;
        r.feas = 1'b1;
        if (is_drone)
        begin
            p = ((sh_ppw * w_sum) >> 8) + sh_base;
            e_over = 1'b0;
            if (p != 0)
            begin
                if (s_over || seg_sum > E_LIM / p)
                begin
                    e_over = 1'b1;
                    energy = T_MAX;
                end
                else
                    energy = (p * seg_sum) >> 8;
            end
            if (e_over)
                sat = 1'b1;
            r.feas = all_dr && !w_over && (w_sum <= sh_cap) && !e_over && (energy <= sh_batt);
        end
        r.rt = t_sum[31:0];
        r.en = energy[31:0];
        r.sat = sat;
        route_q = {route_q, r};
        clear_route();
    endtask

    // customer driver: predict on each transaction, then offer the next item
    always @(posedge clk)
    begin
        bit nv;
        nv = s_tvalid;
        if (s_tvalid && s_tready)
        begin
            eval_customer(cur_cust);
            nv = 1'b0;
        end
        if (!nv && rst_n && cust_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            cur_cust = cust_q.pop_front();
            s_tdata <= {7'd0, cur_cust.dr, cur_cust.svc, cur_cust.dem, cur_cust.y, cur_cust.x};
            s_tuser <= cur_cust.cmd;
            s_tlast <= cur_cust.last;
            nv = 1'b1;
        end
        s_tvalid <= nv;
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        route_res_t e;
        if (m_tvalid && m_tready)
        begin
            if (route_q.size() == 0)
            begin
                $error("unexpected result transaction");
                errs++;
            end
            else
            begin
                e = route_q.pop_front();
                if (m_tdata[31:0] !== e.rt)
                begin
                    $error("route_time exp %h got %h", e.rt, m_tdata[31:0]);
                    errs++;
                end
                if (m_tdata[63:32] !== e.en)
                begin
                    $error("route_energy exp %h got %h", e.en, m_tdata[63:32]);
                    errs++;
                end
                if (m_tdata[64] !== e.feas)
                begin
                    $error("feasible exp %b got %b", e.feas, m_tdata[64]);
                    errs++;
                end
                if (m_tdata[65] !== e.sat)
                begin
                    $error("saturated exp %b got %b", e.sat, m_tdata[65]);
                    errs++;
                end
            end
        end
        m_tready <= rst_n && hold_left == 0 && !(hold_req && !hold_done)
                    && $urandom_range(99) >= recv_stall_pct;
    end

    // register write, shadow updated on the transaction
    task automatic write_reg(input cfg_reg_t idx, input bit [31:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DEPOT:   sh_depot = v;
            REG_TRUCK_T: sh_ttpu = v[15:0];
            REG_DRONE_T: sh_dtpu = v[15:0];
            REG_VERT_T:  sh_vert = v;
            REG_PPW:     sh_ppw = v[15:0];
            REG_BASE_P:  sh_base = v[15:0];
            REG_CAP:     sh_cap = v[23:0];
            REG_BATT:    sh_batt = v;
            default: ;
        endcase
        if (!started)
        begin
            px = dep_x();
            py = dep_y();
        end
    endtask

    task automatic write_all(input bit [31:0] dep, tt, dt, vt, ppw, bp, cap, batt);
        write_reg(REG_DEPOT, dep);
        write_reg(REG_TRUCK_T, tt);
        write_reg(REG_DRONE_T, dt);
        write_reg(REG_VERT_T, vt);
        write_reg(REG_PPW, ppw);
        write_reg(REG_BASE_P, bp);
        write_reg(REG_CAP, cap);
        write_reg(REG_BATT, batt);
    endtask

    task automatic write_random_cfg();
        write_all($urandom, $urandom_range(1024), $urandom_range(1024),
                  $urandom_range(32'h40000), $urandom_range(2048), $urandom_range(2048),
                  $urandom_range(24'h08_0000), $urandom);
    endtask

    task automatic push(input bit cmd, input bit [15:0] x, y, dem, svc, input bit dr, last);
        cust_t c;
        c.cmd = cmd; c.x = x; c.y = y; c.dem = dem; c.svc = svc; c.dr = dr; c.last = last;
        cust_q = {cust_q, c};
    endtask

    // well-formed routes with random content, some broken by mixed kinds
    task automatic gen_routes(input int n);
        int  len;
        bit  cmd;
        bit  near;
        bit [15:0] x, y;
        while (n > 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(6, 1);
            cmd = $urandom_range(1);
            near = $urandom_range(1);
            for (int i = 0; i < len; i++)
            begin
                x = near ? sh_depot[15:0] + $urandom_range(255) : $urandom;
                y = near ? sh_depot[31:16] - $urandom_range(255) : $urandom;
                push(($urandom_range(7) == 0) ? !cmd : cmd, x, y,
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(1023),
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(255),
                     $urandom_range(15) != 0, i == len - 1);
            end
            n -= len;
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (cust_q.size() != 0 || s_tvalid || route_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        sh_depot = 0; sh_ttpu = 256; sh_dtpu = 256; sh_vert = 0;
        sh_ppw = 0; sh_base = 0; sh_cap = W_MAX; sh_batt = T_MAX;
        clear_route();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: extremes of fields, both kinds, mixed kinds
        push(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1);
        push(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1);
        push(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 1);
        push(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1);
        push(1, 16'h1234, 16'h0F00, 16'h0100, 16'h0020, 1, 0);
        push(0, 16'h8000, 16'h7FFF, 16'h0200, 16'h0010, 0, 0);
        push(0, 16'h0001, 16'hFFFE, 16'h0300, 16'h0001, 1, 1);
        push(0, 16'h5555, 16'hAAAA, 16'h0000, 16'h8000, 1, 0);
        push(1, 16'hAAAA, 16'h5555, 16'h0000, 16'h8000, 0, 1);
        drain();

        // power, capacity and battery in play; no idling
        write_all(32'h0400_0300, 32'd128, 32'd200, 32'h0001_8000, 32'd300, 32'd256,
                  32'h00_0800, 32'h0008_0000);
        push(1, 16'h0500, 16'h0500, 16'h0900, 16'h0010, 1, 1);
        push(1, 16'h0500, 16'h0500, 16'h0100, 16'h0010, 1, 1);
        push(1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1, 1);
        gen_routes(300);
        drain();

        // top extremes: saturating time, energy and weight; sender idles
        send_idle_pct = 54;
        write_all(32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF,
                  32'hFF_FFFF, 32'hFFFF_FFFF);
        push(0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1);
        push(1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1);
        for (int i = 0; i < 258; i++)
            push(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1, i == 257);
        gen_routes(300);
        drain();

        // all zero; receiver stalls, plus one long hold-off
        send_idle_pct = 0;
        recv_stall_pct = 54;
        write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        hold_req = 1'b1;
        gen_routes(300);
        drain();

        // random settings, both sides idle
        send_idle_pct = 20;
        recv_stall_pct = 20;
        write_random_cfg();
        gen_routes(300);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_random_cfg();
        gen_routes(300);
        drain();

        if (errs == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tdre_pkg.sv
hw/rtl/tdre_isqrt.sv
hw/rtl/truck_drone_route_evaluator_top.sv
dv/tb.sv
